### design/ssn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssn_pkg
// shared types and constants for the softsign reciprocal pipeline
// ----------------------------------------------------------------------------
package ssn_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W        = 32;
	localparam int PROD_W        = 2 * WORD_W;
	localparam int RES_W         = 18;
	localparam int IP_W          = 7;   // integer part of 1+|x| stays below 128
	localparam int K_W           = 3;
	localparam int NUM_CELLS     = 4;
	localparam int IN_TDATA_W    = 32;
	localparam int OUT_TDATA_W   = 24;

	// data handed from cell to cell
	typedef struct packed {
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] den;
		logic signed [WORD_W-1:0] r;
		logic                     sat;
		logic                     last;
	} cell_data_t;

endpackage

### design/ssn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssn_front
// magnitude, saturation check, denominator and reciprocal seed
// ----------------------------------------------------------------------------
module ssn_front #(
	parameter int FRAC_BITS = ssn_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ssn_pkg::WORD_W-1:0] in_x,
	input  logic                              in_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ssn_pkg::cell_data_t               out_data
);

	localparam logic [ssn_pkg::WORD_W:0]   LIMIT = (ssn_pkg::WORD_W+1)'(127) << FRAC_BITS;
	localparam logic [ssn_pkg::WORD_W-1:0] ONE   = ssn_pkg::WORD_W'(1) << FRAC_BITS;
	localparam logic [ssn_pkg::WORD_W-1:0] SEED0 = ssn_pkg::WORD_W'(3) << (FRAC_BITS - 2);

	logic                          v_q;
	logic                          en;
	logic [ssn_pkg::WORD_W:0]      xe;
	logic [ssn_pkg::WORD_W:0]      ax;
	logic [ssn_pkg::WORD_W-1:0]    den;
	logic [ssn_pkg::WORD_W-1:0]    ip_w;
	logic [ssn_pkg::IP_W-1:0]      ip;
	logic [ssn_pkg::K_W-1:0]       k;
	ssn_pkg::cell_data_t           d_s1;

	assign en       = !v_q || out_ready;
	assign in_ready = en;

	always_comb begin
		xe   = {in_x[ssn_pkg::WORD_W-1], in_x};
		ax   = in_x[ssn_pkg::WORD_W-1] ? (~xe + 1'b1) : xe;
		den  = ax[ssn_pkg::WORD_W-1:0] + ONE;
		ip_w = den >> FRAC_BITS;
		ip   = ip_w[ssn_pkg::IP_W-1:0];
		// leading-one position of the integer part
		k = '0;
		for (int i = 1; i < ssn_pkg::IP_W; i++) begin
			if (ip[i]) k = ssn_pkg::K_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			d_s1.x    <= in_x;
			d_s1.den  <= $signed(den);
			d_s1.r    <= $signed(SEED0 >> k);
			d_s1.sat  <= (ax >= LIMIT);
			d_s1.last <= in_last;
		end
	end

	assign out_valid = v_q;
	assign out_data  = d_s1;

endmodule

### design/ssn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssn_cell
// one newton step r = r * (2 - den * r), two multiply stages
// ----------------------------------------------------------------------------
module ssn_cell #(
	parameter int FRAC_BITS = ssn_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ssn_pkg::cell_data_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ssn_pkg::cell_data_t out_data
);

	localparam logic [ssn_pkg::WORD_W-1:0] TWO = ssn_pkg::WORD_W'(2) << FRAC_BITS;

	logic                                va_q;
	logic                                vb_q;
	logic                                en_a;
	logic                                en_b;
	ssn_pkg::cell_data_t                 d_s1;
	logic signed [ssn_pkg::PROD_W-1:0]   p_s1;
	ssn_pkg::cell_data_t                 d_s2;
	logic signed [ssn_pkg::WORD_W-1:0]   t;
	logic signed [ssn_pkg::PROD_W-1:0]   p2;

	assign en_b     = !vb_q || out_ready;
	assign en_a     = !va_q || en_b;
	assign in_ready = en_a;

	// t = 2 - floor(den*r), wrapping in 32 bits
	assign t  = $signed(TWO - p_s1[FRAC_BITS +: ssn_pkg::WORD_W]);
	assign p2 = d_s1.r * t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= 1'b0;
			vb_q <= 1'b0;
		end else begin
			if (en_a) va_q <= in_valid;
			if (en_b) vb_q <= va_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en_a && in_valid) begin
			d_s1 <= in_data;
			p_s1 <= in_data.den * in_data.r;
		end
		if (en_b && va_q) begin
			d_s2.x    <= d_s1.x;
			d_s2.den  <= d_s1.den;
			d_s2.r    <= $signed(p2[FRAC_BITS +: ssn_pkg::WORD_W]);
			d_s2.sat  <= d_s1.sat;
			d_s2.last <= d_s1.last;
		end
	end

	assign out_valid = vb_q;
	assign out_data  = d_s2;

endmodule

### design/softsign_newton_fixed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softsign_newton_fixed
// streaming softsign y = x / (1 + |x|) on signed fixed-point samples
// ----------------------------------------------------------------------------
// Takes one sample per clock and returns one result per clock, in order, while
// the output is not stalled: the front stage forms |x|+1 and the reciprocal seed,
// four newton cells each register den*r and then r*t (one multiplier per stage),
// and the last stage multiplies x by the reciprocal. Samples with |x| of 127.0 or more give
// plus or minus one. Each stage holds its data while the one after it is full,
// so a stalled output only backs up the stages that carry a transaction.
module softsign_newton_fixed #(
	parameter int FRAC_BITS = ssn_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ssn_pkg::IN_TDATA_W-1:0]      s_tdata,   // [31:0] sample_in
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ssn_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [17:0] result_out, rest zero
	output logic                                m_tlast
);

	localparam logic [ssn_pkg::WORD_W-1:0] ONE     = ssn_pkg::WORD_W'(1) << FRAC_BITS;
	localparam logic [ssn_pkg::WORD_W-1:0] NEG_ONE = ~ONE + 1'b1;

	logic                 c_valid [ssn_pkg::NUM_CELLS+1];
	logic                 c_ready [ssn_pkg::NUM_CELLS+1];
	ssn_pkg::cell_data_t  c_data  [ssn_pkg::NUM_CELLS+1];

	logic                                out_v_q;
	logic                                out_en;
	logic [ssn_pkg::RES_W-1:0]           res_q;
	logic                                last_q;
	logic signed [ssn_pkg::PROD_W-1:0]   y_prod;
	logic [ssn_pkg::WORD_W-1:0]          sat_val;

	ssn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_x     ($signed(s_tdata[ssn_pkg::WORD_W-1:0])),
		.in_last  (s_tlast),
		.out_valid(c_valid[0]),
		.out_ready(c_ready[0]),
		.out_data (c_data[0])
	);

	for (genvar g = 0; g < ssn_pkg::NUM_CELLS; g++) begin : g_cell
		ssn_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (c_valid[g]),
			.in_ready (c_ready[g]),
			.in_data  (c_data[g]),
			.out_valid(c_valid[g+1]),
			.out_ready(c_ready[g+1]),
			.out_data (c_data[g+1])
		);
	end

	assign out_en                       = !out_v_q || m_tready;
	assign c_ready[ssn_pkg::NUM_CELLS]  = out_en;

	assign y_prod  = c_data[ssn_pkg::NUM_CELLS].x * c_data[ssn_pkg::NUM_CELLS].r;
	assign sat_val = c_data[ssn_pkg::NUM_CELLS].x[ssn_pkg::WORD_W-1] ? NEG_ONE : ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= c_valid[ssn_pkg::NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && c_valid[ssn_pkg::NUM_CELLS]) begin
			res_q  <= c_data[ssn_pkg::NUM_CELLS].sat ? sat_val[ssn_pkg::RES_W-1:0]
			                                         : y_prod[FRAC_BITS +: ssn_pkg::RES_W];
			last_q <= c_data[ssn_pkg::NUM_CELLS].last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(ssn_pkg::OUT_TDATA_W-ssn_pkg::RES_W){1'b0}}, res_q};
	assign m_tlast  = last_q;

endmodule

### tb/softsign_newton_fixed_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softsign_newton_fixed_test
// self-checking testbench for the streaming softsign block
// ----------------------------------------------------------------------------
// Feeds signed fixed-point samples over the input stream, with directed corner
// values first and then a random mix. The expected softsign of each accepted
// sample is computed here: saturation at 127.0, a seed of 0.75 shifted down by
// the leading-one position, four newton steps, and the final multiply, all
// with floor-shifted products. Both stream sides idle at random. Every output
// transaction is compared against the oldest expected result.
module softsign_newton_fixed_test;

	localparam int    FB        = ssn_pkg::FRAC_BITS_DEF;
	localparam longint ONE_FX   = longint'(1) << FB;
	localparam longint LIMIT_FX = longint'(127) << FB;
	localparam longint SEED_FX  = longint'(3) << (FB - 2);
	localparam int    RANDOM_ITEMS = 850;

	typedef struct {
		logic [ssn_pkg::WORD_W-1:0] sample;
		logic                       last;
	} sample_item_t;

	typedef struct {
		logic [ssn_pkg::RES_W-1:0] result;
		logic                      last;
	} softsign_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [ssn_pkg::IN_TDATA_W-1:0]  s_tdata;   // [31:0] sample_in
	logic                            s_tlast;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [ssn_pkg::OUT_TDATA_W-1:0] m_tdata;   // [17:0] result_out, rest zero
	logic                            m_tlast;

	sample_item_t     samples_pending[$];
	softsign_result_t softsign_expected[$];
	int               mismatch_count = 0;
	logic             sample_taken = 1'b0;
	int               send_gap = 0;
	int               recv_stall = 0;
	logic             send_burst = 1'b0;
	logic             recv_burst = 1'b0;

	softsign_newton_fixed #(
		.FRAC_BITS(FB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// full product, floor shift, then wrap to 32 bits
	function automatic longint fx_mul(longint a, longint b);
		longint            p;
		logic signed [31:0] w;
		p = a * b;
		p = p >>> FB;
		w = p[31:0];
		return longint'(w);
	endfunction

	function automatic logic [ssn_pkg::RES_W-1:0] softsign_of(
		logic signed [ssn_pkg::WORD_W-1:0] x);
		longint xv;
		longint ax;
		longint den;
		longint ip;
		longint r;
		longint t;
		longint y;
		logic signed [31:0] w;
		int     k;
		xv = longint'(x);
		ax = (xv < 0) ? -xv : xv;
		if (ax >= LIMIT_FX) begin
			y = (xv > 0) ? ONE_FX : -ONE_FX;
		end else begin
			den = ax + ONE_FX;
			ip  = den >> FB;
			k   = 0;
			while (k < 62 && (ip >> (k + 1)) != 0)
				k++;
			r = SEED_FX >>> k;
			for (int i = 0; i < 4; i++) begin
				w = 32'(2 * ONE_FX - fx_mul(den, r));
				t = longint'(w);
				r = fx_mul(r, t);
			end
			y = fx_mul(xv, r);
		end
		return y[ssn_pkg::RES_W-1:0];
	endfunction

	task automatic queue_sample(logic [ssn_pkg::WORD_W-1:0] value, logic last);
		sample_item_t item;
		item.sample = value;
		item.last   = last;
		samples_pending.push_back(item);
	endtask

	// mostly no gap, some short, a few long
	function automatic int random_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 30);
	endfunction

	// input driver: changes on the falling edge
	always @(negedge clk) begin
		sample_item_t item;
		if (arst_n && (!s_tvalid || sample_taken)) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap--;
			end else if (samples_pending.size() > 0) begin
				item = samples_pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= item.sample;
				s_tlast  <= item.last;
				if ($urandom_range(0, 99) == 0)
					send_burst = !send_burst;
				send_gap = send_burst ? 0 : random_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0)
				recv_burst = !recv_burst;
			if (recv_stall > 0) begin
				m_tready <= 1'b0;
				recv_stall--;
			end else begin
				m_tready <= 1'b1;
				recv_stall = recv_burst ? 0 : random_gap();
			end
		end
	end

	// record accepted samples and check results on the rising edge
	always @(posedge clk) begin
		softsign_result_t exp_res;
		sample_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			exp_res.result = softsign_of(s_tdata);
			exp_res.last   = s_tlast;
			softsign_expected.push_back(exp_res);
		end
		if (m_tvalid && m_tready) begin
			if (softsign_expected.size() == 0) begin
				$display("%0t: unexpected transaction, tdata %h tlast %b",
					$time, m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				exp_res = softsign_expected.pop_front();
				if (m_tdata !== ssn_pkg::OUT_TDATA_W'(exp_res.result)) begin
					$display("%0t: result mismatch, expected %h actual %h",
						$time, ssn_pkg::OUT_TDATA_W'(exp_res.result), m_tdata);
					mismatch_count++;
				end
				if (m_tlast !== exp_res.last) begin
					$display("%0t: last mismatch, expected %b actual %b",
						$time, exp_res.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		logic signed [ssn_pkg::WORD_W-1:0] v;
		int                                 pick;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		arst_n   = 1'b0;

		// directed corners: saturation edges, zero, seed boundaries
		queue_sample(32'h0000_0000, 1'b0);
		queue_sample(32'h0000_0001, 1'b0);
		queue_sample(32'hFFFF_FFFF, 1'b0);
		queue_sample(32'h7FFF_FFFF, 1'b1);
		queue_sample(32'h8000_0000, 1'b0);
		queue_sample(32'h007F_0000, 1'b0);
		queue_sample(32'h007E_FFFF, 1'b0);
		queue_sample(32'hFF81_0000, 1'b1);
		queue_sample(32'hFF81_0001, 1'b0);
		queue_sample(32'h0001_0000, 1'b0);
		queue_sample(32'hFFFF_0000, 1'b0);
		queue_sample(32'h0000_8000, 1'b0);
		queue_sample(32'h0000_FFFF, 1'b0);
		queue_sample(32'h0003_0000, 1'b1);
		queue_sample(32'h0002_FFFF, 1'b0);
		queue_sample(32'h0007_0000, 1'b0);
		queue_sample(32'hFFF1_0000, 1'b0);
		queue_sample(32'h001F_0000, 1'b0);
		queue_sample(32'h003F_0000, 1'b0);
		queue_sample(32'hFFC0_FFFF, 1'b1);
		queue_sample(32'h5A5A_5A5A, 1'b0);
		queue_sample(32'hA5A5_A5A5, 1'b1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				v = $urandom_range(0, 32'h007E_FFFF);
			else if (pick < 6)
				v = $urandom_range(0, 32'h0004_0000);
			else if (pick < 8)
				v = $urandom();
			else if (pick == 8)
				v = 32'(LIMIT_FX + $urandom_range(0, 4) - 2);
			else
				v = (((32'd1 << $urandom_range(0, 6)) - 1) << FB) + $urandom_range(0, 4) - 2;
			if ($urandom_range(0, 1))
				v = -v;
			queue_sample(v, $urandom_range(0, 7) == 0);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (samples_pending.size() > 0 || s_tvalid)
			@(posedge clk);
		while (softsign_expected.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && softsign_expected.size() == 0) begin
			$display("[softsign_newton_fixed] OK");
		end else begin
			$display("[softsign_newton_fixed] ERROR");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("%0t: timeout, %0d results outstanding", $time, softsign_expected.size());
		$display("[softsign_newton_fixed] ERROR");
		$finish;
	end

endmodule
